// File: hw/rtl/tccs_pkg.sv
package tccs_pkg;

	// Field widths of the item and result transactions.
	localparam int OP_W       = 2;
	localparam int CODE_W     = 8;
	localparam int CELL_IDX_W = 12;
	localparam int POS_W      = 12;
	localparam int ATTR_W     = 8;
	localparam int DATA_W     = ATTR_W + CODE_W;

	// Default screen geometry.
	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 35;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	// Character codes and the attribute after reset.
	localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'h0A;
	localparam logic [CODE_W-1:0] BLANK_CODE   = 8'h20;
	localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

	typedef struct packed {
		logic [OP_W-1:0]       op;
		logic [CODE_W-1:0]     char_code;
		logic [CELL_IDX_W-1:0] cell_index;
	} in_item_t;

	typedef struct packed {
		logic [POS_W-1:0]  cursor_pos;
		logic [DATA_W-1:0] cell_data;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;         // capture the incoming item
		logic put;          // store a character and move the cursor
		logic rd_item;      // read the cell that the item addresses
		logic home;         // move the cursor to the top left cell
		logic sweep_start;  // restart the sweep counter at cell zero
		logic copy;         // move one cell up by one row
		logic blank;        // blank the cell at the sweep counter
		logic post;         // load the result register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            scroll;     // the cursor move runs off the last row
		logic            idx_ok;     // the read address lies on the screen
		logic            copy_last;  // sweep counter at the last cell to copy
		logic            cell_last;  // sweep counter at the last cell
		logic            out_free;   // the result register can take a result
	} status_t;

endpackage

// File: hw/rtl/tccs_datapath.sv
module tccs_datapath #(
	parameter int COLUMNS = tccs_pkg::DEF_COLUMNS,
	parameter int ROWS    = tccs_pkg::DEF_ROWS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tccs_pkg::in_item_t                  in_item,
	input  logic                                cfg_wr_en,
	input  logic [tccs_pkg::ATTR_W-1:0]         cfg_wr_data,
	input  tccs_pkg::cmd_t                      cmd,
	output tccs_pkg::status_t                   status,
	output logic                                out_valid,
	input  logic                                out_stall,
	output tccs_pkg::out_item_t                 out_item
);
	import tccs_pkg::*;

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int CELL_AW    = $clog2(CELL_COUNT);
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int ROW_W      = $clog2(ROWS);
	localparam int IDX_CMP_W  = ((CELL_AW > CELL_IDX_W) ? CELL_AW : CELL_IDX_W) + 1;

	localparam logic [CELL_AW-1:0] COLS_A     = CELL_AW'(COLUMNS);
	localparam logic [CELL_AW-1:0] COPY_LAST  = CELL_AW'(CELL_COUNT - COLUMNS - 1);
	localparam logic [CELL_AW-1:0] CELL_LAST  = CELL_AW'(CELL_COUNT - 1);
	localparam logic [COL_W:0]     COLS_END   = (COL_W + 1)'(COLUMNS);
	localparam logic [ROW_W:0]     ROWS_END   = (ROW_W + 1)'(ROWS);
	localparam logic [ROW_W-1:0]   ROW_BOTTOM = ROW_W'(ROWS - 1);

	typedef enum logic [1:0] {
		WR_CHAR,
		WR_BLANK,
		WR_COPY
	} wr_sel_t;

	logic [OP_W-1:0]       op_q;
	logic [CODE_W-1:0]     code_q;
	logic [CELL_IDX_W-1:0] idx_q;
	logic                  idx_ok_q;
	logic [ATTR_W-1:0]     attr_q;
	logic [COL_W-1:0]      col_q;
	logic [ROW_W-1:0]      row_q;
	logic [CELL_AW-1:0]    cnt_q;

	logic                  wr_s1;
	logic [CELL_AW-1:0]    wr_addr_s1;
	wr_sel_t               wr_sel_s1;
	logic [DATA_W-1:0]     rdata_s1;
	logic [DATA_W-1:0]     screen_mem [CELL_COUNT];

	logic                  out_valid_q;
	logic [POS_W-1:0]      out_pos_q;
	logic [DATA_W-1:0]     out_data_q;

	logic                  newline;
	logic [COL_W:0]        col_inc;
	logic                  wrap;
	logic [ROW_W:0]        row_inc;
	logic                  scroll;
	logic [CELL_AW-1:0]    cur_addr;
	logic                  rd_en;
	logic [CELL_AW-1:0]    rd_addr;
	logic [DATA_W-1:0]     wr_data;
	logic                  in_idx_ok;

	// Cursor move for a put.
	always_comb begin
		newline  = (code_q == NEWLINE_CODE);
		col_inc  = {1'b0, col_q} + 1'b1;
		wrap     = !newline && (col_inc == COLS_END);
		row_inc  = {1'b0, row_q} + 1'b1;
		scroll   = (newline || wrap) && (row_inc == ROWS_END);
		cur_addr = CELL_AW'(row_q) * COLS_A + CELL_AW'(col_q);
	end

	assign in_idx_ok = IDX_CMP_W'(in_item.cell_index) < IDX_CMP_W'(CELL_COUNT);

	always_comb begin
		rd_en   = cmd.rd_item || cmd.copy;
		rd_addr = cmd.copy ? (cnt_q + COLS_A) : CELL_AW'(idx_q);
		case (wr_sel_s1)
			WR_CHAR:  wr_data = {attr_q, code_q};
			WR_BLANK: wr_data = {attr_q, BLANK_CODE};
			WR_COPY:  wr_data = rdata_s1;
			default:  wr_data = {attr_q, BLANK_CODE};
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_s1) begin
			screen_mem[wr_addr_s1] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= screen_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= in_item.op;
			code_q   <= in_item.char_code;
			idx_q    <= in_item.cell_index;
			idx_ok_q <= in_idx_ok;
		end
		if (cmd.put) begin
			wr_addr_s1 <= cur_addr;
			wr_sel_s1  <= WR_CHAR;
		end else begin
			wr_addr_s1 <= cnt_q;
			wr_sel_s1  <= cmd.copy ? WR_COPY : WR_BLANK;
		end
		if (cmd.post) begin
			out_pos_q  <= POS_W'(cur_addr);
			out_data_q <= (op_q == OP_READ && idx_ok_q) ? rdata_s1 : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q      <= ATTR_RESET;
			col_q       <= '0;
			row_q       <= '0;
			cnt_q       <= '0;
			wr_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				attr_q <= cfg_wr_data;
			end
			if (cmd.home) begin
				col_q <= '0;
				row_q <= '0;
			end else if (cmd.put) begin
				col_q <= (newline || wrap) ? '0 : col_inc[COL_W-1:0];
				if (scroll) begin
					row_q <= ROW_BOTTOM;
				end else if (newline || wrap) begin
					row_q <= row_inc[ROW_W-1:0];
				end
			end
			if (cmd.sweep_start) begin
				cnt_q <= '0;
			end else if (cmd.copy || cmd.blank) begin
				cnt_q <= cnt_q + 1'b1;
			end
			wr_s1 <= (cmd.put && !newline) || cmd.copy || cmd.blank;
			if (cmd.post) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		status.op        = op_q;
		status.scroll    = scroll;
		status.idx_ok    = idx_ok_q;
		status.copy_last = (cnt_q == COPY_LAST);
		status.cell_last = (cnt_q == CELL_LAST);
		status.out_free  = !out_valid_q || !out_stall;
	end

	assign out_valid           = out_valid_q;
	assign out_item.cursor_pos = out_pos_q;
	assign out_item.cell_data  = out_data_q;

endmodule

// File: hw/rtl/tccs_ctrl.sv
module tccs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  tccs_pkg::status_t status,
	output tccs_pkg::cmd_t    cmd
);
	import tccs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_COPY,
		ST_BLANK,
		ST_CLEAR,
		ST_POST
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   in_stall_q;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (status.op)
					OP_PUT: begin
						cmd.put = 1'b1;
						if (status.scroll) begin
							cmd.sweep_start = 1'b1;
							state_nx        = ST_COPY;
						end else begin
							state_nx = ST_POST;
						end
					end
					OP_CLEAR: begin
						cmd.home        = 1'b1;
						cmd.sweep_start = 1'b1;
						state_nx        = ST_CLEAR;
					end
					OP_READ: begin
						cmd.rd_item = status.idx_ok;
						state_nx    = ST_POST;
					end
					default: begin
						state_nx = ST_POST;
					end
				endcase
			end
			ST_COPY: begin
				cmd.copy = 1'b1;
				if (status.copy_last) begin
					state_nx = ST_BLANK;
				end
			end
			ST_BLANK, ST_CLEAR: begin
				cmd.blank = 1'b1;
				if (status.cell_last) begin
					state_nx = ST_POST;
				end
			end
			ST_POST: begin
				if (status.out_free) begin
					cmd.post = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_stall_q <= 1'b0;
		end else begin
			state_q    <= state_nx;
			in_stall_q <= (state_nx != ST_IDLE);
		end
	end

	assign in_stall = in_stall_q;

endmodule

// File: hw/rtl/text_console_cursor_scroll_core.sv
// Text console engine with a COLUMNS x ROWS character screen and a cursor. Each input
// transaction is a put, a clear or a read, and each one gives exactly one result
// transaction carrying the linear cursor position (row times COLUMNS plus column) and,
// for a read of a cell on the screen, the stored cell with the attribute in the high
// byte. A put stores the character with the current attribute at the cursor and moves
// the cursor; the newline code only moves it to the start of the next row. Running off
// the bottom row scrolls the screen up one row and blanks the bottom row. A clear blanks
// every cell and homes the cursor. Blank cells hold a space with the current attribute.
// Items are handled one at a time. A read, an unused operation, or a put that does not
// scroll passes through the dispatch and post states to the result; a scrolling put
// and a clear also sweep every cell of the screen in turn, since the screen store has one
// write port and the sweep moves or blanks one cell per cycle. The result
// sits in an output register, so the next transaction is taken while it waits. Reading
// a cell that was never written returns an unspecified value. The attribute register
// resets to 0x0F and may only be written while no transaction is in flight.
module text_console_cursor_scroll_core #(
	parameter int COLUMNS = tccs_pkg::DEF_COLUMNS,
	parameter int ROWS    = tccs_pkg::DEF_ROWS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  tccs_pkg::in_item_t          in_item,
	output logic                        out_valid,
	input  logic                        out_stall,
	output tccs_pkg::out_item_t         out_item,
	input  logic                        cfg_wr_en,
	input  logic [tccs_pkg::ATTR_W-1:0] cfg_wr_data
);
	import tccs_pkg::*;

	cmd_t    cmd;
	status_t status;

	// The controller sequences each transaction: capture, dispatch, the cell
	// sweep for a scroll or a clear, then a wait until the result register is free.
	tccs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the screen store, the cursor, the attribute register, the sweep
	// counter and the result register.
	tccs_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_item     (in_item),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_item    (out_item)
	);

endmodule
